// File: sv/point_grid_binning_min_max_core_assert.svh
// assertion macros for the point grid binning core
// used by the top level only; expects clk and rst_n in scope
`ifndef POINT_GRID_BINNING_MIN_MAX_CORE_ASSERT_SVH
`define POINT_GRID_BINNING_MIN_MAX_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PGB_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PGB_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/pgb_pkg.sv
// shared types and constants for the point grid binning core
// no dependencies; imported by pgb_binner and the top level
package pgb_pkg;

  localparam int COORD_W     = 16;
  localparam int SHIFT_W     = 4;
  localparam int DIM_CFG_W   = 7;
  localparam int SEL_W       = 12;
  localparam int OUT_COUNT_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 128;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;

  // default sizes of the grid store
  localparam int MAX_COLS_DEF   = 64;
  localparam int MAX_ROWS_DEF   = 64;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = '1;

  // item kinds on the input channel
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD        = 2'd0,
    KIND_READ       = 2'd1,
    KIND_READ_CLEAR = 2'd2
  } kind_t;

  // result status on the output channel
  typedef enum logic [STATUS_W-1:0] {
    ST_STORED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTRE_X     = 3'd0,
    REG_CENTRE_Y     = 3'd1,
    REG_HEIGHT_LIMIT = 3'd2,
    REG_CELL_SHIFT   = 3'd3,
    REG_COLS_IN_USE  = 3'd4,
    REG_ROWS_IN_USE  = 3'd5
  } cfg_reg_t;

  // one stored point, x in the low bits
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // configuration register set
  typedef struct packed {
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic signed [COORD_W-1:0] height_limit;
    logic [SHIFT_W-1:0]        cell_shift;
    logic [DIM_CFG_W-1:0]      cols_in_use;
    logic [DIM_CFG_W-1:0]      rows_in_use;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    centre_x:     16'sd0,
    centre_y:     16'sd3840,
    height_limit: 16'sd256,
    cell_shift:   4'd7,
    cols_in_use:  7'd60,
    rows_in_use:  7'd60
  };

endpackage

// File: sv/pgb_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module pgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/pgb_binner.sv
// maps a point's x and y to a grid cell in three pipeline steps
// depends on pgb_pkg
module pgb_binner #(
  parameter int MAX_COLS = pgb_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = pgb_pkg::MAX_ROWS_DEF,
  localparam int ADDR_W = $clog2(MAX_COLS * MAX_ROWS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [pgb_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [pgb_pkg::COORD_W-1:0]  pos_y,
  input  pgb_pkg::cfg_t                       cfg,
  output logic                                done,
  output logic                                in_grid,
  output logic [ADDR_W-1:0]                   cell_idx
);

  import pgb_pkg::*;

  localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int NUM_W   = DIM_W + 17;

  logic [DIM_W-1:0]        cols_n;
  logic [DIM_W-1:0]        rows_n;
  logic signed [NUM_W-1:0] dx;
  logic signed [NUM_W-1:0] dy;
  logic signed [NUM_W-1:0] num_x;
  logic signed [NUM_W-1:0] num_y;
  logic [DIM_W:0]          bin_x;
  logic [DIM_W:0]          bin_y;

  logic                    v1_r;
  logic                    v2_r;
  logic                    v3_r;
  logic signed [NUM_W-1:0] num_x_r;
  logic signed [NUM_W-1:0] num_y_r;
  logic                    ok_x_r;
  logic                    ok_y_r;
  logic [DIM_W-1:0]        col_r;
  logic [DIM_W-1:0]        row_r;
  logic                    in_grid_r;
  logic [ADDR_W-1:0]       cell_r;

  // num / 2^(s+1) rounded half away from zero; top bit flags 0 <= result < n
  function automatic logic [DIM_W:0] round_bin(
    input logic signed [NUM_W-1:0] num,
    input logic [SHIFT_W-1:0]      s,
    input logic [DIM_W-1:0]        n
  );
    logic [NUM_W-1:0]        pw;
    logic [NUM_W-1:0]        q;
    logic signed [NUM_W-1:0] t;
    logic                    ok;
    logic [DIM_W-1:0]        idx;
    pw = NUM_W'(1) << s;
    q  = '0;
    t  = '0;
    if (!num[NUM_W-1]) begin
      q   = (NUM_W'(num) + pw) >> (5'(s) + 5'd1);
      ok  = q < NUM_W'(n);
      idx = DIM_W'(q);
    end else begin
      // negative side rounds to zero only within half a cell
      t   = num + $signed(pw);
      ok  = (t > 0) && (n != '0);
      idx = '0;
    end
    return {ok, idx};
  endfunction

  // grid size in use, clamped to the store
  assign cols_n = (32'(cfg.cols_in_use) > 32'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                          : DIM_W'(cfg.cols_in_use);
  assign rows_n = (32'(cfg.rows_in_use) > 32'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                          : DIM_W'(cfg.rows_in_use);

  // step 1: numerator 2*(p - centre) + n * 2^s
  assign dx    = NUM_W'(pos_x) - NUM_W'(cfg.centre_x);
  assign dy    = NUM_W'(pos_y) - NUM_W'(cfg.centre_y);
  assign num_x = (dx <<< 1) + $signed(NUM_W'(cols_n) << cfg.cell_shift);
  assign num_y = (dy <<< 1) + $signed(NUM_W'(rows_n) << cfg.cell_shift);

  // step 2: rounding shift and range check
  assign bin_x = round_bin(num_x_r, cfg.cell_shift, cols_n);
  assign bin_y = round_bin(num_y_r, cfg.cell_shift, rows_n);

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // data pipe; step 3 forms column + row * cols
  always_ff @(posedge clk) begin
    num_x_r   <= num_x;
    num_y_r   <= num_y;
    ok_x_r    <= bin_x[DIM_W];
    ok_y_r    <= bin_y[DIM_W];
    col_r     <= bin_x[DIM_W-1:0];
    row_r     <= bin_y[DIM_W-1:0];
    in_grid_r <= ok_x_r && ok_y_r;
    cell_r    <= ADDR_W'(ADDR_W'(row_r) * ADDR_W'(cols_n)) + ADDR_W'(col_r);
  end

  assign done     = v3_r;
  assign in_grid  = in_grid_r;
  assign cell_idx = cell_r;

endmodule

// File: sv/point_grid_binning_min_max_core.sv
// point grid binning core: per-cell count and lowest / highest point
// depends on pgb_pkg, pgb_ram, pgb_binner and the assertion macro header
//
//  channel | ports                         | moves
//  --------+-------------------------------+-------------------------------------
//  in      | in_tvalid/in_tready/tdata/tuser| add point, read cell, read and clear
//  out     | out_tvalid/out_tready/tdata/tuser| one result per input item
//  cfg     | cfg_wr_en/cfg_index/cfg_wdata | register writes, no handshake
//
// one item at a time: add point passes the 3-step binner, a ram read and the update,
// a point outside the grid skips the ram read, a read or read-and-clear skips the binner,
// a dropped point or a read beyond the store goes straight to the final step;
// a stored point or a read-and-clear is a single read-modify-write of one cell record
// after reset a clearing pass zeroes all MAX_COLS*MAX_ROWS ram records (4096 by default)
// a waiting result sits in the output register; the next item is taken meanwhile
// and holds in its final step until the output register is free
`include "point_grid_binning_min_max_core_assert.svh"

module point_grid_binning_min_max_core #(
  parameter int MAX_COLS   = pgb_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = pgb_pkg::MAX_ROWS_DEF,
  parameter int COUNT_BITS = pgb_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pos_x[15:0], pos_y[31:16], pos_z[47:32], cell_select[59:48], zero pad
  input  logic [pgb_pkg::IN_DATA_W-1:0]      in_tdata,
  // kind[1:0]
  input  logic [pgb_pkg::KIND_W-1:0]         in_tuser,
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // cell_index[11:0], point_count[27:12], low_x, low_y, low_z,
  // high_x, high_y, high_z (16 bits each from bit 28), zero pad
  output logic [pgb_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status[1:0]
  output logic [pgb_pkg::STATUS_W-1:0]       out_tuser,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [pgb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pgb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import pgb_pkg::*;

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    point_t                high;
    point_t                low;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BIN,
    S_READ,
    S_MOD
  } state_t;

  typedef enum logic [2:0] {
    OP_STORE,
    OP_READ,
    OP_CLEAR,
    OP_DROP,
    OP_OUTSIDE,
    OP_BEYOND
  } op_t;

  state_t                    state_r;
  op_t                       op_r;
  cfg_t                      cfg_r;
  logic [ADDR_W-1:0]         clr_addr_r;
  logic [ADDR_W-1:0]         addr_r;
  logic [SEL_W-1:0]          sel_r;
  point_t                    pt_r;
  logic                      out_tvalid_r;
  logic [OUT_DATA_W-1:0]     out_tdata_r;
  logic [STATUS_W-1:0]       out_tuser_r;

  logic signed [COORD_W-1:0] in_pos_x;
  logic signed [COORD_W-1:0] in_pos_y;
  logic signed [COORD_W-1:0] in_pos_z;
  logic [SEL_W-1:0]          in_sel;
  logic                      in_xfer;
  logic                      in_drop;
  logic                      in_beyond;
  logic                      out_free;
  logic                      out_load;

  logic                      bin_start;
  logic                      bin_done;
  logic                      bin_in_grid;
  logic [ADDR_W-1:0]         bin_cell;

  logic                      ram_wr_en;
  logic [ADDR_W-1:0]         ram_wr_addr;
  logic [REC_W-1:0]          ram_wr_data;
  logic                      ram_rd_en;
  logic [REC_W-1:0]          ram_rd_data;

  rec_t                      rec_old;
  rec_t                      rec_nxt;
  rec_t                      res_rec;
  logic [OUT_COUNT_W-1:0]    res_count;
  logic [SEL_W-1:0]          res_index;
  status_t                   res_status;

  // input unpacking
  assign in_pos_x  = in_tdata[15:0];
  assign in_pos_y  = in_tdata[31:16];
  assign in_pos_z  = in_tdata[47:32];
  assign in_sel    = in_tdata[59:48];

  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign out_load  = (state_r == S_MOD) && out_free;

  // height limit and origin filter, read range check
  assign in_drop   = (in_pos_z > cfg_r.height_limit) ||
                     ((in_pos_x == '0) && (in_pos_y == '0) && (in_pos_z == '0));
  assign in_beyond = 32'(in_sel) >= 32'(DEPTH);
  assign bin_start = in_xfer && (in_tuser == KIND_ADD) && !in_drop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CENTRE_X:     cfg_r.centre_x     <= cfg_wdata;
        REG_CENTRE_Y:     cfg_r.centre_y     <= cfg_wdata;
        REG_HEIGHT_LIMIT: cfg_r.height_limit <= cfg_wdata;
        REG_CELL_SHIFT:   cfg_r.cell_shift   <= cfg_wdata[SHIFT_W-1:0];
        REG_COLS_IN_USE:  cfg_r.cols_in_use  <= cfg_wdata[DIM_CFG_W-1:0];
        REG_ROWS_IN_USE:  cfg_r.rows_in_use  <= cfg_wdata[DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // coordinate to cell mapping
  pgb_binner #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_binner (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (bin_start),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .cfg      (cfg_r),
    .done     (bin_done),
    .in_grid  (bin_in_grid),
    .cell_idx (bin_cell)
  );

  // cell record store
  pgb_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (addr_r),
    .rd_data (ram_rd_data)
  );

  // ram access: clearing pass, or write-back in the final step; the next read
  // comes only after the write, so no forwarding is needed
  assign ram_rd_en   = (state_r == S_READ);
  assign ram_wr_en   = (state_r == S_CLEAR) ||
                       ((state_r == S_MOD) && out_free &&
                        ((op_r == OP_STORE) || (op_r == OP_CLEAR)));
  assign ram_wr_addr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
  assign ram_wr_data = (state_r == S_CLEAR) ? '0 : REC_W'(rec_nxt);
  assign rec_old     = rec_t'(ram_rd_data);

  // record update: first point sets both ends, then strict improvements only
  always_comb begin
    rec_nxt = rec_old;
    case (op_r)
      OP_STORE: begin
        if (rec_old.count == '0) begin
          rec_nxt.low  = pt_r;
          rec_nxt.high = pt_r;
        end else begin
          if (pt_r.z > rec_old.high.z) begin
            rec_nxt.high = pt_r;
          end
          if (pt_r.z < rec_old.low.z) begin
            rec_nxt.low = pt_r;
          end
        end
        if (rec_old.count != '1) begin
          rec_nxt.count = rec_old.count + COUNT_BITS'(1);
        end
      end
      OP_CLEAR: rec_nxt = '0;
      default:  rec_nxt = rec_old;
    endcase
  end

  // result fields
  always_comb begin
    case (op_r)
      OP_STORE: begin
        res_rec    = rec_nxt;
        res_index  = SEL_W'(addr_r);
        res_status = ST_STORED;
      end
      OP_READ, OP_CLEAR: begin
        res_rec    = rec_old;
        res_index  = sel_r;
        res_status = ST_READ;
      end
      OP_BEYOND: begin
        res_rec    = '0;
        res_index  = sel_r;
        res_status = ST_READ;
      end
      OP_DROP: begin
        res_rec    = '0;
        res_index  = '0;
        res_status = ST_DROPPED;
      end
      default: begin
        res_rec    = '0;
        res_index  = '0;
        res_status = ST_OUTSIDE;
      end
    endcase
  end

  // point count saturates at the output field width
  assign res_count = (32'(res_rec.count) > 32'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                                 : OUT_COUNT_W'(res_rec.count);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // output valid: loaded in the final step, dropped after its transfer
      out_tvalid_r <= out_load || (out_tvalid_r && !out_tready);
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            pt_r   <= '{z: in_pos_z, y: in_pos_y, x: in_pos_x};
            sel_r  <= in_sel;
            addr_r <= ADDR_W'(in_sel);
            case (in_tuser)
              KIND_ADD: begin
                if (in_drop) begin
                  op_r    <= OP_DROP;
                  state_r <= S_MOD;
                end else begin
                  op_r    <= OP_STORE;
                  state_r <= S_BIN;
                end
              end
              KIND_READ_CLEAR: begin
                op_r    <= in_beyond ? OP_BEYOND : OP_CLEAR;
                state_r <= in_beyond ? S_MOD : S_READ;
              end
              default: begin
                op_r    <= in_beyond ? OP_BEYOND : OP_READ;
                state_r <= in_beyond ? S_MOD : S_READ;
              end
            endcase
          end
        end
        S_BIN: begin
          if (bin_done) begin
            addr_r <= bin_cell;
            if (bin_in_grid) begin
              state_r <= S_READ;
            end else begin
              op_r    <= OP_OUTSIDE;
              state_r <= S_MOD;
            end
          end
        end
        S_READ: begin
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (out_free) begin
            out_tuser_r  <= res_status;
            out_tdata_r  <= {4'b0000, res_rec.high, res_rec.low, res_count, res_index};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // checks
  `PGB_CHECK_NOW(a_bin_only_when_waiting, bin_done, state_r == S_BIN, "binner result outside bin step")
  `PGB_CHECK_NEXT(a_busy_after_accept, in_xfer, state_r != S_IDLE, "idle right after an accepted item")
  `PGB_CHECK_NOW(a_stored_count_nonzero, out_tvalid && (out_tuser == ST_STORED), out_tdata[27:12] != '0, "stored point with zero count")
  `PGB_CHECK_NOW(a_read_in_store, ram_rd_en, 32'(addr_r) < 32'(DEPTH), "ram read beyond store")

endmodule
